// ===== hdl/vlt_pkg.sv =====
package vlt_pkg;

    localparam int MaxVoxelsDef = 64;
    localparam int QueueDepth   = 2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic        [15:0] length_limit;
    } t_req;

    typedef struct packed {
        logic signed [7:0] voxel_x;
        logic signed [7:0] voxel_y;
        logic signed [7:0] voxel_z;
        logic              last;
        logic              truncated;
    } t_res;

    // classified line, as handed from the front to the walker
    typedef struct packed {
        logic [2:0][8:0]  fdist;  // |first face - start| in 1/256 voxel
        logic [2:0][15:0] dmag;   // |dir| in 1/16384
        logic [2:0]       neg;    // axis walks downward
        logic [2:0]       nz;     // axis has a nonzero direction
        logic [2:0][7:0]  vox;    // start voxel
        logic [15:0]      lim;
    } t_line;

endpackage

// ===== hdl/vlt_front.sv =====
module vlt_front import vlt_pkg::*; (
    input  t_req  i_req,
    output t_line o_line
);

    logic signed [15:0] pos [3];
    logic signed [15:0] dir [3];
    logic        [7:0]  m   [3];
    logic        [16:0] sum [3];

    assign pos[AX_X] = i_req.start_x;
    assign pos[AX_Y] = i_req.start_y;
    assign pos[AX_Z] = i_req.start_z;
    assign dir[AX_X] = i_req.dir_x;
    assign dir[AX_Y] = i_req.dir_y;
    assign dir[AX_Z] = i_req.dir_z;

    always_comb begin
        o_line.lim = i_req.length_limit;
        for (int a = 0; a < 3; a++) begin
            o_line.nz[a]   = (dir[a] != 16'sd0);
            o_line.neg[a]  = dir[a][15];
            o_line.dmag[a] = dir[a][15] ? (~dir[a] + 16'd1) : dir[a];
            // fraction of the start inside its voxel, offset by half a voxel
            m[a]   = pos[a][7:0] ^ 8'h80;
            sum[a] = {pos[a][15], pos[a]} + 17'd128;
            o_line.vox[a] = sum[a][15:8];
            if (!dir[a][15]) begin
                o_line.fdist[a] = 9'd256 - {1'b0, m[a]};
            end else if (m[a] == 8'd0) begin
                o_line.fdist[a] = 9'd256;   // start on a face: next face one voxel on
            end else begin
                o_line.fdist[a] = {1'b0, m[a]};
            end
        end
    end

endmodule

// ===== hdl/vlt_queue.sv =====
module vlt_queue import vlt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_line i_data,
    input  logic  i_pop,
    output t_line o_data,
    output logic  o_full,
    output logic  o_avail
);

    t_line      r_mem [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QueueDepth));
    assign o_avail = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== hdl/vlt_walk.sv =====
module vlt_walk import vlt_pkg::*; #(
    parameter int MAX_VOXELS = MaxVoxelsDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_avail,
    input  t_line i_line,
    output logic  o_pop,
    output t_res  o_res,
    output logic  o_strobe
);

    localparam int CW = $clog2(MAX_VOXELS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_C0   = 3'd2;
    localparam logic [2:0] S_C1   = 3'd3;
    localparam logic [2:0] S_C2   = 3'd4;
    localparam logic [2:0] S_STEP = 3'd5;

    logic [2:0]       r_state;
    logic [2:0][15:0] r_dist;
    logic [2:0][15:0] r_dmag;
    logic [2:0]       r_neg, r_nz;
    logic [2:0][7:0]  r_vox;
    logic [2:0][7:0]  r_pend;
    logic [15:0]      r_lim;
    logic [21:0]      r_cur_n;
    logic [15:0]      r_cur_d;
    logic [CW-1:0]    r_count;
    logic [2:0]       r_mask;
    logic [37:0]      r_pa, r_pb;
    logic             r_lt_yx, r_eq_xy, r_lt_zx, r_eq_xz;
    t_res             r_res;
    logic             r_stb;

    logic [21:0] tn [3];
    logic [15:0] td [3];
    logic [1:0]  pi, pj;
    logic        more;
    logic        lt_zy, eq_yz, b_y, b_z;
    logic [1:0]  bi, ai;
    logic [2:0]  tie;
    logic [7:0]  nv;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            tn[a] = r_nz[a] ? {r_dist[a], 6'b0} : (22'(r_lim) + 22'd256);
            td[a] = r_nz[a] ? r_dmag[a] : 16'd256;
        end
        unique case (r_state)
            S_C0:    begin pi = AX_X; pj = AX_Z; end
            S_C1:    begin pi = AX_Y; pj = AX_Z; end
            default: begin pi = AX_X; pj = AX_Y; end
        endcase
        more  = ({2'b0, r_cur_n, 8'b0} < (32'(r_lim) * 32'(r_cur_d)));
        lt_zy = (r_pb < r_pa);
        eq_yz = (r_pa == r_pb);
        b_y   = r_lt_yx;
        b_z   = b_y ? lt_zy : r_lt_zx;
        if (b_z) begin
            bi  = AX_Z;
            tie = {1'b1, eq_yz, r_eq_xz};
        end else if (b_y) begin
            bi  = AX_Y;
            tie = {eq_yz, 1'b1, r_eq_xy};
        end else begin
            bi  = AX_X;
            tie = {r_eq_xz, r_eq_xy, 1'b1};
        end
        priority if (r_mask[AX_X]) ai = AX_X;
        else if (r_mask[AX_Y])     ai = AX_Y;
        else                       ai = AX_Z;
        nv = r_neg[ai] ? (r_vox[ai] - 8'd1) : (r_vox[ai] + 8'd1);
    end

    assign o_pop    = (r_state == S_IDLE) && i_avail;
    assign o_res    = r_res;
    assign o_strobe = r_stb;

    // datapath
    always_ff @(posedge i_clk) begin
        r_pa <= 38'(tn[pi]) * 38'(td[pj]);
        r_pb <= 38'(tn[pj]) * 38'(td[pi]);
        unique case (r_state)
            S_IDLE: begin
                for (int a = 0; a < 3; a++) begin
                    r_dist[a] <= 16'(i_line.fdist[a]);
                end
                r_dmag  <= i_line.dmag;
                r_neg   <= i_line.neg;
                r_nz    <= i_line.nz;
                r_vox   <= i_line.vox;
                r_pend  <= i_line.vox;
                r_lim   <= i_line.lim;
                r_cur_n <= 22'd0;
                r_cur_d <= 16'd1;
                r_count <= CW'(1);
            end
            S_C0: begin
                r_lt_yx <= (r_pb < r_pa);
                r_eq_xy <= (r_pa == r_pb);
            end
            S_C1: begin
                r_lt_zx <= (r_pb < r_pa);
                r_eq_xz <= (r_pa == r_pb);
            end
            S_C2: begin
                r_cur_n <= tn[bi];
                r_cur_d <= td[bi];
                r_mask  <= tie & r_nz;
            end
            S_STEP: begin
                if (r_mask != 3'd0 && r_count != CW'(MAX_VOXELS)) begin
                    // pending voxel tracks r_vox, so only the stepped axis moves
                    r_vox[ai]     <= nv;
                    r_pend[ai]    <= nv;
                    r_dist[ai]    <= r_dist[ai] + 16'd256;
                    r_count       <= r_count + CW'(1);
                    r_mask[ai]    <= 1'b0;
                end
            end
            default: ;
        endcase
        r_res.voxel_x   <= r_pend[AX_X];
        r_res.voxel_y   <= r_pend[AX_Y];
        r_res.voxel_z   <= r_pend[AX_Z];
        r_res.last      <= (r_state == S_CHK) || (r_count == CW'(MAX_VOXELS));
        r_res.truncated <= (r_state == S_STEP) && (r_count == CW'(MAX_VOXELS));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stb   <= 1'b0;
        end else begin
            r_stb <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_avail) r_state <= S_CHK;
                S_CHK: begin
                    if (more) begin
                        r_state <= S_C0;
                    end else begin
                        r_stb   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_C0: r_state <= S_C1;
                S_C1: r_state <= S_C2;
                S_C2: r_state <= S_STEP;
                S_STEP: begin
                    if (r_mask == 3'd0) begin
                        r_state <= S_CHK;
                    end else begin
                        r_stb <= 1'b1;
                        if (r_count == CW'(MAX_VOXELS)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/voxel_line_traversal_3d.sv =====
// 3D voxel line walk (face-crossing traversal in exact fixed point).
// Request channel: drive i_req with a line (start Q8.8, direction Q2.14,
// length Q8.8) and raise i_start; the request is taken on a clock edge with
// i_start high and o_busy low. o_busy is high while the two-entry request
// queue is full.
// Result channel: each visited voxel shows on o_res for one cycle with
// o_res_strobe high; the receiver cannot hold results off. o_res.last marks
// the final voxel of a line, o_res.truncated marks a walk cut at MAX_VOXELS.
// Timing: after the walker pops a line it passes S_CHK, S_C0, S_C1, S_C2
// and S_STEP before the start voxel shows (a further round when the first
// round steps no axis; straight from S_CHK when the limit is zero). Each
// face crossing round runs three pairwise distance compares through a
// shared pair of multipliers, then a decision, then steps one voxel per
// cycle and closes the round; the end of a line costs one further check
// in S_CHK.
// The front classifies a request in the cycle it is taken, so up to two
// lines wait while one is walked.
// Reset: queue empties, walker returns to idle, fill_value returns to 1.
// i_cfg_we / i_cfg_data write fill_value.
module voxel_line_traversal_3d import vlt_pkg::*; #(
    parameter int MAX_VOXELS = MaxVoxelsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_res        o_res,
    output logic        o_res_strobe
);

    logic [15:0] r_fill_value;   // fill_value, written through i_cfg_we / i_cfg_data

    t_line line_in, line_out;
    logic  q_full, q_avail, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_value <= 16'd1;
        end else if (i_cfg_we) begin
            r_fill_value <= i_cfg_data;
        end
    end

    assign o_busy = q_full;

    // front: per-axis step direction, first face distance, start voxel
    vlt_front u_front (
        .i_req  (i_req),
        .o_line (line_in)
    );

    vlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_start && !q_full),
        .i_data  (line_in),
        .i_pop   (q_pop),
        .o_data  (line_out),
        .o_full  (q_full),
        .o_avail (q_avail)
    );

    // back: crossing compares and voxel stepping
    vlt_walk #(
        .MAX_VOXELS (MAX_VOXELS)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (q_avail),
        .i_line   (line_out),
        .o_pop    (q_pop),
        .o_res    (o_res),
        .o_strobe (o_res_strobe)
    );

endmodule
